/* rtl/core/ispv_pkg.sv */
`default_nettype none

package ispv_pkg;

    // Default depth of the pixel queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // Variant codes, in output order
    localparam logic [1:0] VAR_NORMAL = 2'd0;
    localparam logic [1:0] VAR_CLICK  = 2'd1;
    localparam logic [1:0] VAR_DIS    = 2'd2;
    localparam logic [1:0] VAR_DCLICK = 2'd3;

    // Configuration register values
    localparam logic MODE_OPAQUE = 1'b0;
    localparam logic MODE_ALPHA  = 1'b1;

    // Grey pull offsets: 3 * 216 and 3 * 188
    localparam logic [9:0] GREY_DIS_OFS    = 10'd648;
    localparam logic [9:0] GREY_DCLICK_OFS = 10'd564;

    // floor(x/5) for x < 16384 as (x * 3277) >> 14
    localparam logic [11:0] DIV5_RECIP = 12'd3277;
    localparam int          DIV5_SHIFT = 14;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // One queued pixel with the mode it was accepted under
    typedef struct packed {
        logic       alpha_mode;
        logic [7:0] chan_0;
        logic [7:0] chan_1;
        logic [7:0] chan_2;
        logic [7:0] alpha_in;
    } t_entry;

    // Divide an 11-bit value by five
    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [22:0] prod;
        prod = {12'd0, x} * {11'd0, DIV5_RECIP};
        return prod[DIV5_SHIFT +: 8];
    endfunction

    // One colour byte of one variant
    function automatic logic [7:0] chan_variant(input logic mode, input logic [1:0] v,
                                                input logic [7:0] c);
        logic [10:0] x;
        logic [7:0]  res;
        x   = {1'b0, c, 2'b00};
        res = div5(x);
        if (mode == MODE_OPAQUE) begin
            case (v)
                VAR_NORMAL: res = c;
                VAR_CLICK:  res = div5({1'b0, c, 2'b00});
                VAR_DIS:    res = div5({2'b00, c, 1'b0} + {1'b0, GREY_DIS_OFS});
                VAR_DCLICK: res = div5({2'b00, c, 1'b0} + {1'b0, GREY_DCLICK_OFS});
                default:    res = c;
            endcase
        end else if (v != VAR_CLICK && v != VAR_DCLICK) begin
            res = c;
        end
        return res;
    endfunction

    // Alpha byte of one variant
    function automatic logic [7:0] alpha_variant(input logic mode, input logic [1:0] v,
                                                 input logic [7:0] a);
        logic [7:0] res;
        res = a;
        if (mode == MODE_OPAQUE) begin
            res = ALPHA_OPAQUE;
        end else if (v == VAR_DIS || v == VAR_DCLICK) begin
            res = {1'b0, a[7:1]};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/ispv_front.sv */
`default_nettype none

module ispv_front
    import ispv_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // configuration
    input  wire logic       i_cfg_valid,
    input  wire logic       i_cfg_data,
    output logic            o_cfg_ready,
    // pixel input
    input  wire logic       i_valid,
    input  wire logic [7:0] i_chan_0,
    input  wire logic [7:0] i_chan_1,
    input  wire logic [7:0] i_chan_2,
    input  wire logic [7:0] i_alpha_in,
    output logic            o_stall,
    // to queue
    input  wire logic       i_q_full,
    output logic            o_push,
    output t_entry          o_entry
);

    logic r_alpha_mode;
    logic n_alpha_mode;

    // mode register, always writable
    assign o_cfg_ready  = 1'b1;
    assign n_alpha_mode = (i_cfg_valid && o_cfg_ready) ? i_cfg_data : r_alpha_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_mode <= MODE_OPAQUE;
        end else begin
            r_alpha_mode <= n_alpha_mode;
        end
    end

    // accept while the queue has room; tag pixel with its mode
    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        o_entry.alpha_mode = r_alpha_mode;
        o_entry.chan_0     = i_chan_0;
        o_entry.chan_1     = i_chan_1;
        o_entry.chan_2     = i_chan_2;
        // alpha byte is irrelevant in opaque mode
        o_entry.alpha_in   = (r_alpha_mode == MODE_ALPHA) ? i_alpha_in : 8'd0;
    end

endmodule

`default_nettype wire

/* rtl/core/ispv_queue.sv */
`default_nettype none

module ispv_queue
    import ispv_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    input  wire logic   i_pop,
    output logic        o_full,
    output logic        o_avail,
    output t_entry      o_head
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

    t_entry        r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_wr_ptr;
    logic [AW-1:0] n_rd_ptr;
    logic [CW-1:0] n_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_avail = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/ispv_back.sv */
`default_nettype none

module ispv_back
    import ispv_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    // from queue
    input  wire logic   i_avail,
    input  wire t_entry i_head,
    output logic        o_pop,
    // result output
    output logic        o_valid,
    input  wire logic   i_stall,
    output logic [1:0]  o_variant,
    output logic [7:0]  o_out_0,
    output logic [7:0]  o_out_1,
    output logic [7:0]  o_out_2,
    output logic [7:0]  o_alpha_out,
    output logic        o_last
);

    logic       r_valid;
    logic [1:0] r_var_cnt;
    logic [1:0] r_variant;
    logic [7:0] r_out_0;
    logic [7:0] r_out_1;
    logic [7:0] r_out_2;
    logic [7:0] r_alpha_out;
    logic       r_last;
    logic       w_adv;
    logic       w_load;

    // output register moves when empty or taken
    assign w_adv  = !r_valid || !i_stall;
    assign w_load = w_adv && i_avail;
    assign o_pop  = w_load && (r_var_cnt == VAR_DCLICK);

    // control: valid flag and variant counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_var_cnt <= VAR_NORMAL;
        end else begin
            if (w_adv) begin
                r_valid <= i_avail;
            end
            if (w_load) begin
                r_var_cnt <= r_var_cnt + 1'b1;
            end
        end
    end

    // result payload for the current variant
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_variant   <= r_var_cnt;
            r_out_0     <= chan_variant(i_head.alpha_mode, r_var_cnt, i_head.chan_0);
            r_out_1     <= chan_variant(i_head.alpha_mode, r_var_cnt, i_head.chan_1);
            r_out_2     <= chan_variant(i_head.alpha_mode, r_var_cnt, i_head.chan_2);
            r_alpha_out <= alpha_variant(i_head.alpha_mode, r_var_cnt, i_head.alpha_in);
            r_last      <= (r_var_cnt == VAR_DCLICK);
        end
    end

    assign o_valid     = r_valid;
    assign o_variant   = r_variant;
    assign o_out_0     = r_out_0;
    assign o_out_1     = r_out_1;
    assign o_out_2     = r_out_2;
    assign o_alpha_out = r_alpha_out;
    assign o_last      = r_last;

endmodule

`default_nettype wire

/* rtl/core/icon_state_pixel_variants.sv */
// Icon state pixel variants: each source pixel (three colour bytes and an
// alpha byte) yields four derived pixels in order normal, clicked, disabled,
// disabled-clicked; the fourth carries o_last.
// Channels: pixel input (i_valid / o_stall), result output (o_valid /
// i_stall), a transaction moves when valid is high and stall is low.
// The mode register is written through i_cfg_valid / o_cfg_ready /
// i_cfg_data (0 opaque, 1 alpha); write it only while the block is idle.
// The input transaction is written into the queue; the sequencer then loads
// the first result into the output register from the queue head.
// The pixel rate is set by the output channel, which carries one derived pixel
// per cycle while it is not stalled. A queue of QUEUE_DEPTH pixels sits
// between the input stage and the variant sequencer, so input keeps being
// accepted while results wait.
// Reset (synchronous, active low) empties the queue, drops any pending
// result and returns to opaque mode. A stalled output holds its payload;
// once the queue fills, o_stall rises.
`default_nettype none

module icon_state_pixel_variants
    import ispv_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    input  wire logic       i_cfg_data,
    output logic            o_cfg_ready,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_chan_0,
    input  wire logic [7:0] i_chan_1,
    input  wire logic [7:0] i_chan_2,
    input  wire logic [7:0] i_alpha_in,
    output logic            o_stall,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [1:0]      o_variant,
    output logic [7:0]      o_out_0,
    output logic [7:0]      o_out_1,
    output logic [7:0]      o_out_2,
    output logic [7:0]      o_alpha_out,
    output logic            o_last
);

    logic   w_q_full;
    logic   w_q_avail;
    logic   w_push;
    logic   w_pop;
    t_entry w_entry;
    t_entry w_head;

    // input stage and mode register
    ispv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_valid     (i_valid),
        .i_chan_0    (i_chan_0),
        .i_chan_1    (i_chan_1),
        .i_chan_2    (i_chan_2),
        .i_alpha_in  (i_alpha_in),
        .o_stall     (o_stall),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_entry     (w_entry)
    );

    // pixel queue
    ispv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_avail (w_q_avail),
        .o_head  (w_head)
    );

    // variant sequencer and output register
    ispv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_avail     (w_q_avail),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_variant   (o_variant),
        .o_out_0     (o_out_0),
        .o_out_1     (o_out_1),
        .o_out_2     (o_out_2),
        .o_alpha_out (o_alpha_out),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

/* rtl/core/ispv_checker.sv */
`default_nettype none

module ispv_checker
    import ispv_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [1:0] o_variant,
    input wire logic [7:0] o_out_0,
    input wire logic [7:0] o_alpha_out,
    input wire logic       o_last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_variant) && $stable(o_out_0)
            && $stable(o_alpha_out))
        else $error("stalled result changed");

    // last marks exactly the disabled-clicked variant
    a_last_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == (o_variant == VAR_DCLICK)))
        else $error("last flag does not match variant");

    // variants of one pixel follow back to back in order
    a_var_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last |=> o_valid
            && (o_variant == $past(o_variant) + 2'd1))
        else $error("variant sequence broken");

endmodule

bind icon_state_pixel_variants ispv_checker u_ispv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_variant   (o_variant),
    .o_out_0     (o_out_0),
    .o_alpha_out (o_alpha_out),
    .o_last      (o_last)
);

`default_nettype wire

/* verif/icon_state_pixel_variants_tb.sv */
`timescale 1ns / 100ps

module icon_state_pixel_variants_tb;
    import ispv_pkg::*;

    localparam int RUN_LIMIT  = 400000;
    localparam int SETTLE_CYC = 8;
    localparam int MAX_REPORT = 10;

    // One source pixel
    typedef struct packed {
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] a;
    } t_pixel;

    // One derived pixel as the block should emit it
    typedef struct packed {
        logic [1:0] variant;
        logic [7:0] o0;
        logic [7:0] o1;
        logic [7:0] o2;
        logic [7:0] alpha;
        logic       last;
    } t_shaded_px;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       i_cfg_data  = 1'b0;
    logic       o_cfg_ready;
    logic       i_valid     = 1'b0;
    logic [7:0] i_chan_0    = 8'd0;
    logic [7:0] i_chan_1    = 8'd0;
    logic [7:0] i_chan_2    = 8'd0;
    logic [7:0] i_alpha_in  = 8'd0;
    logic       o_stall;
    logic       o_valid;
    logic       i_stall     = 1'b0;
    logic [1:0] o_variant;
    logic [7:0] o_out_0;
    logic [7:0] o_out_1;
    logic [7:0] o_out_2;
    logic [7:0] o_alpha_out;
    logic       o_last;

    t_pixel     pixel_q[$];     // pixels waiting to be sent
    t_shaded_px shaded_q[$];    // derived pixels still to come
    logic       tb_mode     = MODE_OPAQUE;
    int         n_queued    = 0;
    int         n_sent      = 0;
    int         err_count   = 0;
    int         cycle_cnt   = 0;
    int         burst_left  = 0;
    int         gap_left    = 0;
    logic [9:0] stall_tick  = '0;

    icon_state_pixel_variants u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_valid     (i_valid),
        .i_chan_0    (i_chan_0),
        .i_chan_1    (i_chan_1),
        .i_chan_2    (i_chan_2),
        .i_alpha_in  (i_alpha_in),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_variant   (o_variant),
        .o_out_0     (o_out_0),
        .o_out_1     (o_out_1),
        .o_out_2     (o_out_2),
        .o_alpha_out (o_alpha_out),
        .o_last      (o_last)
    );

    always #6 i_clk = ~i_clk;

    // Colour byte of one variant
    function automatic logic [7:0] shade_chan(input logic mode, input logic [1:0] v,
                                              input logic [7:0] c);
        int x;
        x = c;
        if (mode == MODE_OPAQUE) begin
            case (v)
                VAR_CLICK:  x = (4 * x) / 5;
                VAR_DIS:    x = (2 * x + 648) / 5;   // toward grey 216
                VAR_DCLICK: x = (2 * x + 564) / 5;   // toward grey 188
                default:    x = c;
            endcase
        end else if (v == VAR_CLICK || v == VAR_DCLICK) begin
            x = (4 * x) / 5;
        end
        return x[7:0];
    endfunction

    // Alpha byte of one variant
    function automatic logic [7:0] shade_alpha(input logic mode, input logic [1:0] v,
                                               input logic [7:0] a);
        if (mode == MODE_OPAQUE)
            return ALPHA_OPAQUE;
        if (v == VAR_DIS || v == VAR_DCLICK)
            return a >> 1;
        return a;
    endfunction

    // Queue the four derived pixels of one accepted source pixel
    task automatic expand_pixel(input t_pixel px);
        t_shaded_px sp;
        logic [1:0] v;
        for (int i = 0; i < 4; i++) begin
            v          = i[1:0];
            sp.variant = v;
            sp.o0      = shade_chan(tb_mode, v, px.c0);
            sp.o1      = shade_chan(tb_mode, v, px.c1);
            sp.o2      = shade_chan(tb_mode, v, px.c2);
            sp.alpha   = shade_alpha(tb_mode, v, px.a);
            sp.last    = (v == VAR_DCLICK);
            shaded_q.push_back(sp);
        end
    endtask

    // Byte biased toward the ends of the range
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'($urandom_range(0, 7));
            3:       return 8'($urandom_range(248, 255));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic queue_pixel(input logic [7:0] c0, input logic [7:0] c1,
                               input logic [7:0] c2, input logic [7:0] a);
        pixel_q.push_back('{c0: c0, c1: c1, c2: c2, a: a});
        n_queued++;
    endtask

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++)
            queue_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte());
    endtask

    task automatic queue_directed();
        queue_pixel(8'd0,   8'd0,   8'd0,   8'd0);
        queue_pixel(8'd255, 8'd255, 8'd255, 8'd255);
        queue_pixel(8'd0,   8'd255, 8'd0,   8'd128);
        queue_pixel(8'd255, 8'd0,   8'd255, 8'd1);
        queue_pixel(8'd1,   8'd2,   8'd3,   8'd254);
        queue_pixel(8'd4,   8'd5,   8'd6,   8'd127);
        queue_pixel(8'd216, 8'd188, 8'd100, 8'd0);
        queue_pixel(8'd5,   8'd10,  8'd15,  8'd170);
        queue_pixel(8'd170, 8'd85,  8'd170, 8'd85);
        queue_pixel(8'd85,  8'd170, 8'd85,  8'd170);
        queue_pixel(8'd254, 8'd253, 8'd252, 8'd2);
        queue_pixel(8'd128, 8'd64,  8'd32,  8'd3);
    endtask

    // Hold off until every sent pixel has produced all its variants
    task automatic wait_idle();
        do @(negedge i_clk);
        while (n_sent != n_queued || shaded_q.size() != 0);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // Mode register write; only called while idle
    task automatic write_mode(input logic m);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        tb_mode      = m;
        i_cfg_valid <= 1'b0;
    endtask

    // Pixel driver: bursts with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            burst_left = $urandom_range(1, 16);
            gap_left   = 0;
        end else begin
            if (i_valid && !o_stall) begin
                expand_pixel('{c0: i_chan_0, c1: i_chan_1, c2: i_chan_2, a: i_alpha_in});
                n_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pixel_q.size() != 0) begin
                    t_pixel px;
                    px          = pixel_q.pop_front();
                    i_valid    <= 1'b1;
                    i_chan_0   <= px.c0;
                    i_chan_1   <= px.c1;
                    i_chan_2   <= px.c2;
                    i_alpha_in <= px.a;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result stall pattern: none, light, heavy, periodic
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            stall_tick <= stall_tick + 10'd1;
            case (stall_tick[9:8])
                2'd0:    i_stall <= 1'b0;
                2'd1:    i_stall <= ($urandom_range(0, 3) == 0);
                2'd2:    i_stall <= ($urandom_range(0, 9) < 6);
                default: i_stall <= (stall_tick[2:0] == 3'd5) || (stall_tick[2:0] == 3'd6);
            endcase
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            t_shaded_px want;
            if (shaded_q.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORT)
                    $display("unexpected result: variant %0d out %0d %0d %0d",
                             o_variant, o_out_0, o_out_1, o_out_2,
                             " alpha %0d last %0b", o_alpha_out, o_last);
            end else begin
                want = shaded_q.pop_front();
                if (o_variant !== want.variant || o_out_0 !== want.o0 ||
                    o_out_1 !== want.o1 || o_out_2 !== want.o2 ||
                    o_alpha_out !== want.alpha || o_last !== want.last) begin
                    err_count++;
                    if (err_count <= MAX_REPORT)
                        $display("mismatch: exp v%0d %0d %0d %0d a%0d l%0b,",
                                 want.variant, want.o0, want.o1, want.o2,
                                 want.alpha, want.last,
                                 " got v%0d %0d %0d %0d a%0d l%0b",
                                 o_variant, o_out_0, o_out_1, o_out_2,
                                 o_alpha_out, o_last);
                end
            end
        end
    end

    // Run limit
    initial begin
        while (cycle_cnt < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Test sequence
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed pixels in both modes
        queue_directed();
        wait_idle();
        write_mode(MODE_ALPHA);
        queue_directed();
        wait_idle();

        // random phases; first one pauses midway until drained
        queue_random(17);
        wait_idle();
        queue_random(18);
        wait_idle();
        write_mode(MODE_OPAQUE);
        queue_random(25);
        wait_idle();
        write_mode(MODE_ALPHA);
        queue_random(22);
        wait_idle();
        write_mode(MODE_OPAQUE);
        queue_random(22);
        wait_idle();

        if (err_count == 0 && shaded_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/ispv_pkg.sv
rtl/core/ispv_front.sv
rtl/core/ispv_queue.sv
rtl/core/ispv_back.sv
rtl/core/icon_state_pixel_variants.sv
rtl/core/ispv_checker.sv
verif/icon_state_pixel_variants_tb.sv
